[hw/rtl/lpi_pkg.sv]
// shared types, widths and codes of the line-plane intersection block
// no dependencies
package lpi_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    // q - p, products and dot-product sums at full width
    localparam int QP_WIDTH  = COORD_WIDTH + 1;
    localparam int NV_WIDTH  = 2 * COORD_WIDTH;
    localparam int NE_WIDTH  = 2 * COORD_WIDTH + 1;
    localparam int D_WIDTH   = 2 * COORD_WIDTH + 2;
    localparam int E_WIDTH   = 2 * COORD_WIDTH + 3;
    localparam int N_WIDTH   = E_WIDTH + FRAC_BITS;
    localparam int S_WIDTH   = 2 * COORD_WIDTH + 1;

    localparam int IDX_WIDTH   = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_CNT_W = 3;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_POINT = 2'd1;
    localparam logic [1:0] KIND_PLANE = 2'd2;

    localparam logic [IDX_WIDTH-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [IDX_WIDTH-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [IDX_WIDTH-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [IDX_WIDTH-1:0] REG_DIR_X    = 3'd3;
    localparam logic [IDX_WIDTH-1:0] REG_DIR_Y    = 3'd4;
    localparam logic [IDX_WIDTH-1:0] REG_DIR_Z    = 3'd5;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] plane_normal_x;
        logic signed [COORD_WIDTH-1:0] plane_normal_y;
        logic signed [COORD_WIDTH-1:0] plane_normal_z;
        logic signed [COORD_WIDTH-1:0] plane_point_x;
        logic signed [COORD_WIDTH-1:0] plane_point_y;
        logic signed [COORD_WIDTH-1:0] plane_point_z;
    } lpi_in_t;

    typedef struct packed {
        logic [1:0]                    hit_kind;
        logic signed [COORD_WIDTH-1:0] hit_x;
        logic signed [COORD_WIDTH-1:0] hit_y;
        logic signed [COORD_WIDTH-1:0] hit_z;
        logic                          overflow;
    } lpi_out_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] origin_x;
        logic signed [COORD_WIDTH-1:0] origin_y;
        logic signed [COORD_WIDTH-1:0] origin_z;
        logic signed [COORD_WIDTH-1:0] dir_x;
        logic signed [COORD_WIDTH-1:0] dir_y;
        logic signed [COORD_WIDTH-1:0] dir_z;
    } lpi_line_t;

    // classified item handed from front to back
    typedef struct packed {
        logic [1:0]                kind;
        logic signed [D_WIDTH-1:0] d;
        logic signed [E_WIDTH-1:0] e;
    } lpi_task_t;

endpackage

[hw/rtl/lpi_front.sv]
// front end: accepts plane beats, forms d = n.v and e = n.(q-p), classifies
// depends on lpi_pkg
module lpi_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               plane_valid,
    output logic               plane_stall,
    input  lpi_pkg::lpi_in_t   plane,
    input  lpi_pkg::lpi_line_t line,
    output logic               push,
    output lpi_pkg::lpi_task_t push_data,
    input  logic               full
);

    logic signed [lpi_pkg::COORD_WIDTH-1:0] n [3];
    logic signed [lpi_pkg::COORD_WIDTH-1:0] q [3];
    logic signed [lpi_pkg::COORD_WIDTH-1:0] p [3];
    logic signed [lpi_pkg::COORD_WIDTH-1:0] v [3];
    logic signed [lpi_pkg::QP_WIDTH-1:0]    qp [3];
    logic signed [lpi_pkg::NV_WIDTH-1:0]    nv_next [3];
    logic signed [lpi_pkg::NE_WIDTH-1:0]    ne_next [3];
    logic signed [lpi_pkg::NV_WIDTH-1:0]    nv_reg [3];
    logic signed [lpi_pkg::NE_WIDTH-1:0]    ne_reg [3];
    logic                                   f1_valid_reg;
    logic                                   f2_valid_reg;
    lpi_pkg::lpi_task_t                     f2_reg;
    logic signed [lpi_pkg::D_WIDTH-1:0]     d_sum;
    logic signed [lpi_pkg::E_WIDTH-1:0]     e_sum;
    logic                                   adv;

    assign n[0] = plane.plane_normal_x;
    assign n[1] = plane.plane_normal_y;
    assign n[2] = plane.plane_normal_z;
    assign q[0] = plane.plane_point_x;
    assign q[1] = plane.plane_point_y;
    assign q[2] = plane.plane_point_z;
    assign p[0] = line.origin_x;
    assign p[1] = line.origin_y;
    assign p[2] = line.origin_z;
    assign v[0] = line.dir_x;
    assign v[1] = line.dir_y;
    assign v[2] = line.dir_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qp[i]      = lpi_pkg::QP_WIDTH'(q[i]) - lpi_pkg::QP_WIDTH'(p[i]);
            nv_next[i] = lpi_pkg::NV_WIDTH'(n[i]) * lpi_pkg::NV_WIDTH'(v[i]);
            ne_next[i] = lpi_pkg::NE_WIDTH'(n[i]) * lpi_pkg::NE_WIDTH'(qp[i]);
        end
    end

    // whole front moves unless the last stage is held by a full queue
    assign adv         = !(f2_valid_reg && full);
    assign plane_stall = !adv;
    assign push        = f2_valid_reg && !full;
    assign push_data   = f2_reg;

    assign d_sum = lpi_pkg::D_WIDTH'(nv_reg[0]) + lpi_pkg::D_WIDTH'(nv_reg[1])
                 + lpi_pkg::D_WIDTH'(nv_reg[2]);
    assign e_sum = lpi_pkg::E_WIDTH'(ne_reg[0]) + lpi_pkg::E_WIDTH'(ne_reg[1])
                 + lpi_pkg::E_WIDTH'(ne_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f1_valid_reg <= plane_valid;
            f2_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                nv_reg[i] <= nv_next[i];
                ne_reg[i] <= ne_next[i];
            end
            f2_reg.d <= d_sum;
            f2_reg.e <= e_sum;
            if (d_sum != '0)
                f2_reg.kind <= lpi_pkg::KIND_POINT;
            else if (e_sum == '0)
                f2_reg.kind <= lpi_pkg::KIND_PLANE;
            else
                f2_reg.kind <= lpi_pkg::KIND_NONE;
        end
    end

endmodule

[hw/rtl/lpi_queue.sv]
// short shifting queue between front and back
// depends on lpi_pkg
module lpi_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  lpi_pkg::lpi_task_t push_data,
    output logic               full,
    input  logic               pop,
    output lpi_pkg::lpi_task_t pop_data,
    output logic               not_empty
);

    lpi_pkg::lpi_task_t                 ent_reg [lpi_pkg::QUEUE_DEPTH];
    logic [lpi_pkg::QUEUE_CNT_W-1:0]    count_reg;
    logic [lpi_pkg::QUEUE_CNT_W-1:0]    count_next;
    logic [lpi_pkg::QUEUE_CNT_W-1:0]    count_m1;

    assign full      = count_reg == lpi_pkg::QUEUE_CNT_W'(lpi_pkg::QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign pop_data  = ent_reg[0];
    assign count_m1  = count_reg - 1'b1;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_m1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // head sits at entry 0, entries shift down on pop
    for (genvar i = 0; i < lpi_pkg::QUEUE_DEPTH; i++)
    begin : g_ent
        always_ff @(posedge clk)
        begin
            if (pop)
            begin
                if (push && count_m1 == lpi_pkg::QUEUE_CNT_W'(i))
                    ent_reg[i] <= push_data;
                else if (i < lpi_pkg::QUEUE_DEPTH - 1)
                    ent_reg[i] <= ent_reg[(i + 1) % lpi_pkg::QUEUE_DEPTH];
            end
            else if (push && count_reg == lpi_pkg::QUEUE_CNT_W'(i))
            begin
                ent_reg[i] <= push_data;
            end
        end
    end

endmodule

[hw/rtl/lpi_back.sv]
// back end: pipelined restoring divider for t = e/d, then p + t*v with saturation
// depends on lpi_pkg
module lpi_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               task_valid,
    input  lpi_pkg::lpi_task_t task_in,
    output logic               pop,
    input  lpi_pkg::lpi_line_t line,
    output logic               hit_valid,
    input  logic               hit_stall,
    output lpi_pkg::lpi_out_t  hit
);

    localparam int CW = lpi_pkg::COORD_WIDTH;
    localparam int DW = lpi_pkg::D_WIDTH;
    localparam int EW = lpi_pkg::E_WIDTH;
    localparam int NW = lpi_pkg::N_WIDTH;
    localparam int SW = lpi_pkg::S_WIDTH;
    localparam logic [CW-1:0] HALF  = {1'b1, {(CW - 1){1'b0}}};
    localparam logic [CW-1:0] MAXV  = {1'b0, {(CW - 1){1'b1}}};

    logic adv;

    // operand setup
    logic           neg0;
    logic [EW-1:0]  ue;
    logic [DW-1:0]  ud;
    logic [NW-1:0]  num;
    logic [NW-1:0]  rem0;

    // divider pipeline, stage 0 is the setup register
    logic           dv_valid_reg [CW+1];
    logic [1:0]     dv_kind_reg  [CW+1];
    logic           dv_neg_reg   [CW+1];
    logic           dv_ovf_reg   [CW+1];
    logic [DW-1:0]  dv_ud_reg    [CW+1];
    logic [DW-1:0]  dv_rem_reg   [CW+1];
    logic [CW-1:0]  dv_num_reg   [CW+1];
    logic [CW-1:0]  dv_q_reg     [CW+1];

    // quotient, multiply and output stages
    logic                   t_valid_reg;
    logic [1:0]             t_kind_reg;
    logic                   t_ovf_reg;
    logic signed [CW-1:0]   t_reg;
    logic                   big;
    logic signed [CW-1:0]   t_next;
    logic                   m_valid_reg;
    logic [1:0]             m_kind_reg;
    logic                   m_ovf_reg;
    logic signed [2*CW-1:0] prod_reg [3];
    logic signed [CW-1:0]   v [3];
    logic signed [CW-1:0]   p [3];
    logic signed [2*CW-1:0] sh [3];
    logic signed [SW-1:0]   s [3];
    logic signed [CW-1:0]   c [3];
    logic [2:0]             sat;
    logic                   hit_valid_reg;
    lpi_pkg::lpi_out_t      hit_reg;
    lpi_pkg::lpi_out_t      hit_next;

    assign adv       = !(hit_valid_reg && hit_stall);
    assign pop       = adv && task_valid;
    assign hit_valid = hit_valid_reg;
    assign hit       = hit_reg;

    assign v[0] = line.dir_x;
    assign v[1] = line.dir_y;
    assign v[2] = line.dir_z;
    assign p[0] = line.origin_x;
    assign p[1] = line.origin_y;
    assign p[2] = line.origin_z;

    // magnitudes; a quotient of 2^CW or more is flagged before dividing
    assign neg0 = task_in.d[DW-1] ^ task_in.e[EW-1];
    assign ue   = task_in.e[EW-1] ? EW'(-task_in.e) : EW'(task_in.e);
    assign ud   = task_in.d[DW-1] ? DW'(-task_in.d) : DW'(task_in.d);
    assign num  = NW'(ue) << lpi_pkg::FRAC_BITS;
    assign rem0 = num >> CW;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_valid_reg[0] <= 1'b0;
        else if (adv)
            dv_valid_reg[0] <= task_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_kind_reg[0] <= task_in.kind;
            dv_neg_reg[0]  <= neg0;
            dv_ovf_reg[0]  <= rem0 >= NW'(ud);
            dv_ud_reg[0]   <= ud;
            dv_rem_reg[0]  <= rem0[DW-1:0];
            dv_num_reg[0]  <= num[CW-1:0];
            dv_q_reg[0]    <= '0;
        end
    end

    // one quotient bit per stage
    for (genvar k = 0; k < CW; k++)
    begin : g_div
        logic [DW:0] trial;
        logic [DW:0] diff;

        assign trial = {dv_rem_reg[k], dv_num_reg[k][CW-1]};
        assign diff  = trial - {1'b0, dv_ud_reg[k]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[k+1] <= 1'b0;
            else if (adv)
                dv_valid_reg[k+1] <= dv_valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_kind_reg[k+1] <= dv_kind_reg[k];
                dv_neg_reg[k+1]  <= dv_neg_reg[k];
                dv_ovf_reg[k+1]  <= dv_ovf_reg[k];
                dv_ud_reg[k+1]   <= dv_ud_reg[k];
                dv_num_reg[k+1]  <= dv_num_reg[k] << 1;
                dv_q_reg[k+1]    <= {dv_q_reg[k][CW-2:0], !diff[DW]};
                dv_rem_reg[k+1]  <= diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
            end
        end
    end

    // signed, saturated quotient
    always_comb
    begin
        if (dv_neg_reg[CW])
            big = dv_ovf_reg[CW] || (dv_q_reg[CW] > HALF);
        else
            big = dv_ovf_reg[CW] || (dv_q_reg[CW] > MAXV);
        if (big)
            t_next = dv_neg_reg[CW] ? $signed(HALF) : $signed(MAXV);
        else if (dv_neg_reg[CW])
            t_next = $signed(-dv_q_reg[CW]);
        else
            t_next = $signed(dv_q_reg[CW]);
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sh[i]  = prod_reg[i] >>> lpi_pkg::FRAC_BITS;
            s[i]   = SW'(sh[i]) + SW'(p[i]);
            sat[i] = (s[i][SW-1:CW-1] != '0) && (s[i][SW-1:CW-1] != '1);
            if (!sat[i])
                c[i] = s[i][CW-1:0];
            else if (s[i][SW-1])
                c[i] = $signed(HALF);
            else
                c[i] = $signed(MAXV);
        end
        hit_next = '0;
        hit_next.hit_kind = m_kind_reg;
        if (m_kind_reg == lpi_pkg::KIND_POINT)
        begin
            hit_next.hit_x    = c[0];
            hit_next.hit_y    = c[1];
            hit_next.hit_z    = c[2];
            hit_next.overflow = m_ovf_reg || (sat != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            hit_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            t_valid_reg   <= dv_valid_reg[CW];
            m_valid_reg   <= t_valid_reg;
            hit_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_kind_reg <= dv_kind_reg[CW];
            t_ovf_reg  <= big;
            t_reg      <= t_next;
            m_kind_reg <= t_kind_reg;
            m_ovf_reg  <= t_ovf_reg;
            for (int i = 0; i < 3; i++)
                prod_reg[i] <= (2 * CW)'(t_reg) * (2 * CW)'(v[i]);
            hit_reg    <= hit_next;
        end
    end

    a_no_point_zero: assert property (@(posedge clk) disable iff (!rst_n)
        hit_valid_reg && hit_reg.hit_kind != lpi_pkg::KIND_POINT |->
            hit_reg.hit_x == '0 && hit_reg.hit_y == '0 && hit_reg.hit_z == '0
            && !hit_reg.overflow)
        else $error("fields not cleared for a result without a point");

    a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !adv && t_valid_reg |=>
            $stable(t_valid_reg) && $stable(m_valid_reg) && $stable(t_reg))
        else $error("back pipeline moved while held");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> task_valid && adv)
        else $error("pop from empty queue or while held");

endmodule

[hw/rtl/line_plane_intersection.sv]
// top level of the line-plane intersection block: line registers and wiring
// depends on lpi_pkg, lpi_front, lpi_queue, lpi_back
//
// usage
//   the line is set through the write port: cfg_we with cfg_index 0..5
//   writes origin x/y/z then direction x/y/z (signed q16.16); other indexes
//   are ignored. write only while no beat is in flight
//   reset gives origin 0 and direction (1.0, 0, 0)
//   plane channel: one beat per cycle (plane_valid high, plane_stall low)
//   carries a normal and a point on the plane
//   hit channel: one result beat per plane, in order: hit_kind 0 none,
//   1 point, 2 line in plane; coordinates and overflow are zero unless 1
//   throughput is one beat per cycle while hit_stall is low; the divider is
//   a 32 stage pipeline, one quotient bit per stage
//   a beat runs through the front, queue, divider, quotient, multiply and
//   output registers to hit_valid; when hit_stall is held the back pipeline
//   freezes, the 4 entry queue fills, and plane_stall then freezes the front
module line_plane_intersection (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lpi_pkg::IDX_WIDTH-1:0]       cfg_index,
    input  logic [lpi_pkg::COORD_WIDTH-1:0]     cfg_data,
    input  logic                                plane_valid,
    output logic                                plane_stall,
    input  lpi_pkg::lpi_in_t                    plane,
    output logic                                hit_valid,
    input  logic                                hit_stall,
    output lpi_pkg::lpi_out_t                   hit
);

    lpi_pkg::lpi_line_t line_reg;
    lpi_pkg::lpi_task_t push_data;
    lpi_pkg::lpi_task_t pop_data;
    logic               push;
    logic               pop;
    logic               full;
    logic               not_empty;

    // line registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg <= '{origin_x: '0, origin_y: '0, origin_z: '0,
                          dir_x: lpi_pkg::COORD_WIDTH'(1 << lpi_pkg::FRAC_BITS),
                          dir_y: '0, dir_z: '0};
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lpi_pkg::REG_ORIGIN_X: line_reg.origin_x <= cfg_data;
                lpi_pkg::REG_ORIGIN_Y: line_reg.origin_y <= cfg_data;
                lpi_pkg::REG_ORIGIN_Z: line_reg.origin_z <= cfg_data;
                lpi_pkg::REG_DIR_X:    line_reg.dir_x    <= cfg_data;
                lpi_pkg::REG_DIR_Y:    line_reg.dir_y    <= cfg_data;
                lpi_pkg::REG_DIR_Z:    line_reg.dir_z    <= cfg_data;
                default:               ;
            endcase
        end
    end

    // front: dot products and classification
    lpi_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .plane_valid (plane_valid),
        .plane_stall (plane_stall),
        .plane       (plane),
        .line        (line_reg),
        .push        (push),
        .push_data   (push_data),
        .full        (full)
    );

    // decoupling queue
    lpi_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .not_empty (not_empty)
    );

    // back: divide and form the point
    lpi_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .task_valid (not_empty),
        .task_in    (pop_data),
        .pop        (pop),
        .line       (line_reg),
        .hit_valid  (hit_valid),
        .hit_stall  (hit_stall),
        .hit        (hit)
    );

endmodule

[test/tb_top.sv]
// self-checking testbench of the line-plane intersection block
// depends on lpi_pkg and line_plane_intersection; predicts every hit beat
// from the programmed line and the plane beat, and checks each in order
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lpi_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 50;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [IDX_WIDTH-1:0]   cfg_index;
    logic [COORD_WIDTH-1:0] cfg_data;
    logic                   plane_valid;
    logic                   plane_stall;
    lpi_in_t                plane;
    logic                   hit_valid;
    logic                   hit_stall;
    lpi_out_t               hit;

    line_plane_intersection dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .plane_valid (plane_valid),
        .plane_stall (plane_stall),
        .plane       (plane),
        .hit_valid   (hit_valid),
        .hit_stall   (hit_stall),
        .hit         (hit)
    );

    // testbench copy of the line registers
    lpi_line_t line_regs;

    lpi_in_t  plane_pend[$];   // planes waiting to be offered
    lpi_out_t hit_expected[$]; // predicted hit beats, oldest first

    int  mismatches;
    int  cycles;
    int  send_idle_pct;
    int  stall_pct;
    bit  plane_took;
    int  hold_cnt;
    bit  hold_go;
    bit  hold_done;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // signed q16.16 intersection of the current line with one plane
    function automatic lpi_out_t intersect_plane(lpi_in_t pl);
        logic signed [127:0] nv[3];
        logic signed [127:0] qv[3];
        logic signed [127:0] pv[3];
        logic signed [127:0] dv[3];
        logic signed [127:0] dot_d;
        logic signed [127:0] dot_e;
        logic signed [127:0] t;
        logic signed [127:0] s;
        logic [127:0]        ue;
        logic [127:0]        ud;
        logic [127:0]        quo;
        logic [127:0]        lim;
        logic                neg;
        lpi_out_t            r;
        nv[0] = $signed(pl.plane_normal_x);
        nv[1] = $signed(pl.plane_normal_y);
        nv[2] = $signed(pl.plane_normal_z);
        qv[0] = $signed(pl.plane_point_x);
        qv[1] = $signed(pl.plane_point_y);
        qv[2] = $signed(pl.plane_point_z);
        pv[0] = $signed(line_regs.origin_x);
        pv[1] = $signed(line_regs.origin_y);
        pv[2] = $signed(line_regs.origin_z);
        dv[0] = $signed(line_regs.dir_x);
        dv[1] = $signed(line_regs.dir_y);
        dv[2] = $signed(line_regs.dir_z);
        dot_d = 0;
        dot_e = 0;
        for (int i = 0; i < 3; i++)
        begin
            dot_d = dot_d + nv[i] * dv[i];
            dot_e = dot_e + nv[i] * (qv[i] - pv[i]);
        end
        r = '0;
        // parallel line: either lying in the plane or missing it
        if (dot_d == 0)
        begin
            r.hit_kind = (dot_e == 0) ? KIND_PLANE : KIND_NONE;
            return r;
        end
        neg = dot_e[127] != dot_d[127];
        ue  = dot_e[127] ? -dot_e : dot_e;
        ud  = dot_d[127] ? -dot_d : dot_d;
        quo = (ue << FRAC_BITS) / ud;
        lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        if (quo > lim)
        begin
            r.overflow = 1'b1;
            t = neg ? -128'sh8000_0000 : 128'sh7fff_ffff;
        end
        else
            t = neg ? -$signed(quo) : $signed(quo);
        for (int i = 0; i < 3; i++)
        begin
            s = ((t * dv[i]) >>> FRAC_BITS) + pv[i];
            if (s > 128'sh7fff_ffff)
            begin
                s = 128'sh7fff_ffff;
                r.overflow = 1'b1;
            end
            else if (s < -128'sh8000_0000)
            begin
                s = -128'sh8000_0000;
                r.overflow = 1'b1;
            end
            case (i)
                0: r.hit_x = s[31:0];
                1: r.hit_y = s[31:0];
                default: r.hit_z = s[31:0];
            endcase
        end
        r.hit_kind = KIND_POINT;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
        mismatches++;
    endtask

    // plane driver: a new beat only once the previous one was taken; also drives hit_stall
    always @(negedge clk)
    begin
        if (rst_n && (!plane_valid || plane_took))
        begin
            plane_took = 1'b0;
            if (plane_pend.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                plane       <= plane_pend.pop_front();
                plane_valid <= 1'b1;
            end
            else
                plane_valid <= 1'b0;
        end
        if (rst_n)
            hit_stall <= (hold_cnt != 0) || ($urandom_range(99) < stall_pct);
    end

    // long receiver hold-off, counted on its own
    always @(posedge clk)
    begin
        if (hold_cnt != 0)
            hold_cnt <= hold_cnt - 1;
        else if (hold_go && !hold_done)
        begin
            hold_cnt  <= 300;
            hold_done <= 1'b1;
        end
    end

    // monitor: predict on each accepted plane beat, check each hit beat
    always @(posedge clk)
    begin
        lpi_out_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
        begin
            if (plane_valid && !plane_stall)
            begin
                hit_expected.push_back(intersect_plane(plane));
                plane_took = 1'b1;
            end
            if (hit_valid && !hit_stall)
            begin
                if (hit_expected.size() == 0)
                    report_mismatch("unexpected beat", {30'd0, hit.hit_kind}, 32'd0);
                else
                begin
                    want = hit_expected.pop_front();
                    if (hit.hit_kind !== want.hit_kind)
                        report_mismatch("hit_kind", {30'd0, hit.hit_kind},
                                        {30'd0, want.hit_kind});
                    if (hit.hit_x !== want.hit_x)
                        report_mismatch("hit_x", hit.hit_x, want.hit_x);
                    if (hit.hit_y !== want.hit_y)
                        report_mismatch("hit_y", hit.hit_y, want.hit_y);
                    if (hit.hit_z !== want.hit_z)
                        report_mismatch("hit_z", hit.hit_z, want.hit_z);
                    if (hit.overflow !== want.overflow)
                        report_mismatch("overflow", {31'd0, hit.overflow},
                                        {31'd0, want.overflow});
                end
            end
        end
    end

    task automatic write_line_reg(input logic [IDX_WIDTH-1:0] idx,
                                  input logic [COORD_WIDTH-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ORIGIN_X: line_regs.origin_x = val;
            REG_ORIGIN_Y: line_regs.origin_y = val;
            REG_ORIGIN_Z: line_regs.origin_z = val;
            REG_DIR_X:    line_regs.dir_x    = val;
            REG_DIR_Y:    line_regs.dir_y    = val;
            REG_DIR_Z:    line_regs.dir_z    = val;
            default: ;
        endcase
    endtask

    task automatic set_line(input logic [31:0] ox, input logic [31:0] oy,
                            input logic [31:0] oz, input logic [31:0] vx,
                            input logic [31:0] vy, input logic [31:0] vz);
        write_line_reg(REG_ORIGIN_X, ox);
        write_line_reg(REG_ORIGIN_Y, oy);
        write_line_reg(REG_ORIGIN_Z, oz);
        write_line_reg(REG_DIR_X, vx);
        write_line_reg(REG_DIR_Y, vy);
        write_line_reg(REG_DIR_Z, vz);
    endtask

    // wait until every plane went in and every hit came out
    task automatic wait_drained();
        do
            @(posedge clk);
        while (plane_pend.size() != 0 || plane_valid || hit_expected.size() != 0);
    endtask

    function automatic logic [31:0] small_coord();
        return $signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
    endfunction

    function automatic lpi_in_t plane_with(input logic [31:0] nx, input logic [31:0] ny,
                                           input logic [31:0] nz, input logic [31:0] qx,
                                           input logic [31:0] qy, input logic [31:0] qz);
        lpi_in_t pl;
        pl = {nx, ny, nz, qx, qy, qz};
        return pl;
    endfunction

    // mostly small values that give real points, some full range,
    // some planes parallel to the line, in it, or with a zero normal
    function automatic lpi_in_t random_plane();
        int pick;
        lpi_in_t pl;
        pick = $urandom_range(99);
        if (pick < 55)
            pl = plane_with(small_coord(), small_coord(), small_coord(),
                            small_coord(), small_coord(), small_coord());
        else if (pick < 80)
            pl = plane_with($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        else if (pick < 95)
        begin
            // normal about perpendicular to the direction, exactly so in the second form unless dir_x is -2^31
            pl = plane_with(line_regs.dir_y >>> 8, -(line_regs.dir_x >>> 8), '0,
                            small_coord(), small_coord(), small_coord());
            if ($urandom_range(1))
            begin
                pl.plane_normal_x = line_regs.dir_y;
                pl.plane_normal_y = -line_regs.dir_x;
                pl.plane_point_x  = line_regs.origin_x;
                pl.plane_point_y  = line_regs.origin_y;
                pl.plane_point_z  = $urandom;
            end
        end
        else
            pl = plane_with('0, '0, '0, $urandom, $urandom, $urandom);
        return pl;
    endfunction

    task automatic random_phase(input int count, input int idle, input int stall);
        send_idle_pct = idle;
        stall_pct     = stall;
        for (int i = 0; i < count; i++)
            plane_pend.push_back(random_plane());
        wait_drained();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        plane_valid = 1'b0;
        plane       = '0;
        hit_stall   = 1'b0;
        plane_took  = 1'b0;
        hold_cnt    = 0;
        hold_go     = 1'b0;
        hold_done   = 1'b0;
        mismatches  = 0;
        cycles      = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        line_regs   = '{origin_x: 0, origin_y: 0, origin_z: 0,
                        dir_x: 32'h0001_0000, dir_y: 0, dir_z: 0};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed beats against the reset line along x
        plane_pend.push_back(plane_with('0, '0, '0, 32'h0005_0000, 0, 0));
        plane_pend.push_back(plane_with(32'h0001_0000, 0, 0, 32'h0005_0000, 7, 9));
        plane_pend.push_back(plane_with(32'hffff_0000, 0, 0, 32'hfffb_8000, 0, 0));
        plane_pend.push_back(plane_with(0, 32'h0001_0000, 0, 0, 0, 0));
        plane_pend.push_back(plane_with(0, 32'h0001_0000, 0, 0, 32'h0003_0000, 0));
        plane_pend.push_back(plane_with(32'h7fff_ffff, 0, 0, 32'h7fff_ffff, 0, 0));
        plane_pend.push_back(plane_with(32'h8000_0000, 0, 0, 32'h8000_0000, 0, 0));
        plane_pend.push_back(plane_with(1, 0, 0, 32'h7fff_ffff, 0, 0));
        plane_pend.push_back(plane_with(1, 32'h7fff_ffff, 32'h8000_0000,
                                        32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000));
        plane_pend.push_back(plane_with(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                                        32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
        plane_pend.push_back(plane_with(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        wait_drained();

        // zero direction: only parallel outcomes
        set_line(32'h8000_0000, 32'h0002_0000, 0, 0, 0, 0);
        plane_pend.push_back(plane_with(32'h0001_0000, 0, 0, 32'h8000_0000, 0, 5));
        plane_pend.push_back(plane_with(32'h0001_0000, 0, 0, 0, 0, 0));
        plane_pend.push_back(plane_with(0, 0, 0, 32'h1234_0000, 1, 2));
        random_phase(60, 0, 56);

        // small line, no idling then idle sender
        set_line(small_coord(), small_coord(), small_coord(),
                 small_coord(), small_coord(), small_coord());
        random_phase(200, 0, 0);
        random_phase(150, 56, 0);

        // extreme line, stalling receiver
        set_line(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        plane_pend.push_back(plane_with(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        random_phase(150, 0, 56);

        // unit-scale line with a long receiver hold-off while planes keep coming
        set_line(32'h0001_0000, 32'hffff_0000, 0, 0, 32'h0001_0000, 32'h0000_8000);
        @(negedge clk);
        hold_go = 1'b1;
        random_phase(120, 0, 0);

        // full-range line, then a small line, both sides idling
        set_line($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        random_phase(130, 38, 38);
        set_line(small_coord(), small_coord(), small_coord(),
                 small_coord(), small_coord(), small_coord());
        random_phase(140, 38, 38);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && hit_expected.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
